@@ rtl/upc_pkg.sv @@
// Package for the percent codec: request and result types, character codes,
// mode codes and hex helper functions. No dependencies.
package upc_pkg;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_PATH  = 2'd1;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_PCT   = 2'd1;
    localparam logic [1:0] PEND_DIGIT = 2'd2;

    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DASH       = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_TILDE      = 8'h7E;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] in_byte;
        logic       in_last;
    } upc_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } upc_result_t;

    typedef struct packed {
        logic [1:0]                        count;
        logic [MAX_RESULTS-1:0][7:0]       bytes;
        logic                              last;
    } upc_burst_t;

    typedef struct packed {
        logic [1:0] count;
        logic       taking;
    } upc_buf_status_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    // bit 4 set when c is a hex digit, bits 3:0 its value
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

endpackage

@@ rtl/upc_stream_if.sv @@
// Valid/ready stream channel carrying one payload struct per request.
// Payload type is set at instantiation; no package dependency.
interface upc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/upc_step.sv @@
// Per-request codec logic: escape state and the burst of up to three output
// bytes for one request. Depends on upc_pkg.
module upc_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  upc_pkg::upc_item_t  item,
    output upc_pkg::upc_burst_t burst
);
    import upc_pkg::*;

    logic [1:0] pcount_reg, pcount_next;
    logic [7:0] pdigit_reg, pdigit_next;
    logic       start_reg, start_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= PEND_NONE;
            pdigit_reg <= 8'd0;
            start_reg  <= 1'b1;
        end
        else if (load)
        begin
            pcount_reg <= pcount_next;
            pdigit_reg <= pdigit_next;
            start_reg  <= start_next;
        end
    end

    always_comb
    begin
        logic [1:0]                  n;
        logic [MAX_RESULTS-1:0][7:0] b;
        logic [7:0]                  c;
        logic [4:0]                  hi;
        logic [4:0]                  lo;
        n           = 2'd0;
        b           = '0;
        c           = item.in_byte;
        hi          = hex_val(pdigit_reg);
        lo          = hex_val(c);
        pcount_next = pcount_reg;
        pdigit_next = pdigit_reg;
        if (item.mode[1])
        begin
            case (pcount_reg)
                PEND_NONE:
                begin
                    if (c == CH_PERCENT)
                        pcount_next = PEND_PCT;
                    else
                    begin
                        b[n] = c;
                        n    = n + 2'd1;
                    end
                end
                PEND_PCT:
                begin
                    pdigit_next = c;
                    pcount_next = PEND_DIGIT;
                end
                default:
                begin
                    pcount_next = PEND_NONE;
                    pdigit_next = 8'd0;
                    if (hi[4] && lo[4])
                    begin
                        b[n] = {hi[3:0], lo[3:0]};
                        n    = n + 2'd1;
                    end
                    else
                    begin
                        b[n] = CH_PERCENT;
                        n    = n + 2'd1;
                        if (pdigit_reg == CH_PERCENT)
                            pcount_next = PEND_PCT;
                        else
                        begin
                            b[n] = pdigit_reg;
                            n    = n + 2'd1;
                        end
                        if (pcount_next == PEND_NONE)
                        begin
                            if (c == CH_PERCENT)
                                pcount_next = PEND_PCT;
                            else
                            begin
                                b[n] = c;
                                n    = n + 2'd1;
                            end
                        end
                        else
                        begin
                            pdigit_next = c;
                            pcount_next = PEND_DIGIT;
                        end
                    end
                end
            endcase
            if (item.in_last)
            begin
                if (pcount_next != PEND_NONE)
                begin
                    b[n] = CH_PERCENT;
                    n    = n + 2'd1;
                end
                if (pcount_next == PEND_DIGIT)
                begin
                    b[n] = pdigit_next;
                    n    = n + 2'd1;
                end
            end
        end
        else
        begin
            pcount_next = PEND_NONE;
            pdigit_next = 8'd0;
            if (is_alnum(c) || c == CH_UNDERSCORE ||
                (item.mode == MODE_PLAIN &&
                 (c == CH_DASH || c == CH_DOT || c == CH_TILDE)) ||
                (item.mode == MODE_PATH && !start_reg &&
                 (c == CH_DASH || c == CH_DOT)))
            begin
                b[0] = c;
                n    = 2'd1;
            end
            else
            begin
                b[0] = CH_PERCENT;
                b[1] = hex_char(c[7:4]);
                b[2] = hex_char(c[3:0]);
                n    = 2'd3;
            end
        end
        if (item.in_last)
        begin
            pcount_next = PEND_NONE;
            pdigit_next = 8'd0;
            start_next  = 1'b1;
        end
        else
            start_next = start_reg && (n == 2'd0);
        burst.count = n;
        burst.bytes = b;
        burst.last  = item.in_last;
    end

    a_last_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        load && item.in_last |-> burst.count != 2'd0)
        else $error("end of string produced no output byte");

    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        load && item.in_last |=> pcount_reg == PEND_NONE && start_reg)
        else $error("escape state not cleared at end of string");

endmodule

@@ rtl/upc_outbuf.sv @@
// Result buffer: holds one burst of up to three bytes and drains it one byte
// per request on the result channel. Depends on upc_pkg and upc_stream_if.
module upc_outbuf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  upc_pkg::upc_burst_t     burst,
    output upc_pkg::upc_buf_status_t status,
    upc_stream_if.source            result
);
    import upc_pkg::*;

    logic [MAX_RESULTS-1:0][7:0] bytes_reg, bytes_next;
    logic [1:0]                  cnt_reg, cnt_next;
    logic                        last_reg, last_next;
    logic                        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            last_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    always_comb
    begin
        take       = (cnt_reg != 2'd0) && result.ready;
        bytes_next = bytes_reg;
        cnt_next   = cnt_reg;
        last_next  = last_reg;
        if (load)
        begin
            bytes_next = burst.bytes;
            cnt_next   = burst.count;
            last_next  = burst.last;
        end
        else if (take)
        begin
            bytes_next = {8'h00, bytes_reg[2], bytes_reg[1]};
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    assign result.valid         = cnt_reg != 2'd0;
    assign result.data.out_byte = bytes_reg[0];
    assign result.data.out_last = last_reg && (cnt_reg == 2'd1);
    assign status.count         = cnt_reg;
    assign status.taking        = take;

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        take && !load |=> cnt_reg == $past(cnt_reg) - 2'd1)
        else $error("result buffer count did not advance on take");

endmodule

@@ rtl/url_percent_codec.sv @@
// Top level of the percent codec: request register, step logic, result buffer.
// Depends on upc_pkg, upc_stream_if, upc_step and upc_outbuf.
//
// Percent encoder/decoder on a byte stream. A request carries a mode (plain
// encode, path encode, decode), one byte and an end-of-string mark; it yields
// up to three result bytes, the last of a string flagged with out_last. A
// taken request passes through the request register and the step logic into
// the result buffer, from which its result bytes are taken. A request that
// yields k result bytes occupies the one-byte result port for k transfers, so
// the rate is one request per cycle while the result port is not stalled and
// every byte passes through. A request register in front of the step logic
// holds one request while the result port is stalled.
module url_percent_codec (
    input  logic        clk,
    input  logic        rst_n,
    upc_stream_if.sink   item,
    upc_stream_if.source result
);
    import upc_pkg::*;

    logic            item_valid_reg;
    upc_item_t       item_reg;
    logic            load;
    upc_burst_t      burst;
    upc_buf_status_t status;

    assign load = item_valid_reg &&
                  (status.count == 2'd0 || (status.count == 2'd1 && status.taking));
    assign item.ready = !item_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item.valid && item.ready)
            item_valid_reg <= 1'b1;
        else if (load)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            item_reg <= item.data;
    end

    upc_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .item  (item_reg),
        .burst (burst)
    );

    upc_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .burst  (burst),
        .status (status),
        .result (result)
    );

    a_load_into_free_buffer: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> status.count == 2'd0 || (status.count == 2'd1 && status.taking))
        else $error("burst loaded over undelivered result bytes");

endmodule
